@@ hdl/rrst_pkg.sv @@
// rrst_pkg: shared constants for the read range set table
// operation codes, field widths and the default table depth; no dependencies
`default_nettype none
package rrst_pkg;
  localparam int NumW      = 31;
  localparam int KindW     = 3;
  localparam int IdxW      = 4;
  localparam int CountW    = 5;
  localparam int MaxRanges = 16;

  localparam logic [KindW-1:0] KIND_MARK   = 3'd0;
  localparam logic [KindW-1:0] KIND_QUERY  = 3'd1;
  localparam logic [KindW-1:0] KIND_APPEND = 3'd2;
  localparam logic [KindW-1:0] KIND_FIX    = 3'd3;
  localparam logic [KindW-1:0] KIND_FIRST  = 3'd4;
  localparam logic [KindW-1:0] KIND_READ   = 3'd5;
endpackage
`default_nettype wire

@@ hdl/rrst_ram.sv @@
// rrst_ram: single write port, single read port memory with registered read data
// holds the range table entries; no dependencies
`default_nettype none
module rrst_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 62
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hdl/read_range_set_table.sv @@
// read_range_set_table: sorted table of disjoint number ranges
// depends on rrst_pkg and rrst_ram
//
//   channel | ports                                     | handshake
//   in      | in_kind, in_number, in_low_bound, ...     | start high while busy low
//   out     | out_is_read ... out_range_count           | out_valid, one cycle
//
// A transaction's result strobe follows the taking of start: first unread on an
// empty table, an out-of-range read and unused kinds answer straight from idle;
// a fix that keeps nothing walks every entry and takes the longest.
// The walk reads one entry a cycle from the memory, and an insert, join or fix
// then moves entries one a cycle through the single write port.
// Reset empties the table at once; entries are not cleared.
// The receiver cannot stall; busy holds off new transactions.
`default_nettype none
module read_range_set_table #(
  parameter int MAX_RANGES = rrst_pkg::MaxRanges
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [rrst_pkg::KindW-1:0]  in_kind,
  input  wire logic [rrst_pkg::NumW-1:0]   in_number,
  input  wire logic [rrst_pkg::NumW-1:0]   in_low_bound,
  input  wire logic [rrst_pkg::NumW-1:0]   in_high_bound,
  input  wire logic [rrst_pkg::IdxW-1:0]   in_entry_index,
  output logic                             out_valid,
  output logic                             out_is_read,
  output logic [rrst_pkg::NumW-1:0]        out_first_unread,
  output logic [rrst_pkg::NumW-1:0]        out_entry_low,
  output logic [rrst_pkg::NumW-1:0]        out_entry_high,
  output logic                             out_entry_valid,
  output logic                             out_table_full,
  output logic [rrst_pkg::CountW-1:0]      out_range_count
);
  localparam int NW = rrst_pkg::NumW;
  localparam int AW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_MJOIN, S_COPY, S_SHUP, S_INS, S_INSCHK,
    S_ALAST, S_FLAST, S_FNONE, S_FIRST, S_RDENT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [CW-1:0]              i_r, i_nxt;
  logic [CW-1:0]              j_r, j_nxt;
  logic [CW-1:0]              d_r, d_nxt;
  logic [CW-1:0]              pos_r, pos_nxt;
  logic [rrst_pkg::KindW-1:0] kind_r, kind_nxt;
  logic [NW-1:0]              num_r, num_nxt;
  logic [NW-1:0]              lob_r, lob_nxt;
  logic [NW-1:0]              hib_r, hib_nxt;
  logic [NW-1:0]              sav_lo_r, sav_lo_nxt;
  logic [NW-1:0]              ins_lo_r, ins_lo_nxt;
  logic [NW-1:0]              ins_hi_r, ins_hi_nxt;
  logic                       ov_r, ov_nxt;
  logic                       res_read_r, res_read_nxt;
  logic [NW-1:0]              res_first_r, res_first_nxt;
  logic [NW-1:0]              res_elo_r, res_elo_nxt;
  logic [NW-1:0]              res_ehi_r, res_ehi_nxt;
  logic                       res_ev_r, res_ev_nxt;
  logic                       res_full_r, res_full_nxt;

  // memory port signals
  logic                       we;
  logic [AW-1:0]              waddr, raddr;
  logic [2*NW-1:0]            wdata, rdata;
  logic [NW-1:0]              rd_lo, rd_hi;
  logic [NW:0]                n1, hi1, rd_lo32;
  logic [NW-1:0]              app_lo, app_hi;
  logic [NW-1:0]              fix_h;
  logic                       w_end;

  rrst_ram #(.DEPTH(MAX_RANGES), .WIDTH(2*NW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_lo   = rdata[2*NW-1:NW];
  assign rd_hi   = rdata[NW-1:0];
  assign n1      = {1'b0, num_r} + 1'b1;
  assign hi1     = {1'b0, rd_hi} + 1'b1;
  assign rd_lo32 = {1'b0, rd_lo};
  assign w_end   = 32'(i_r) >= 32'(cnt_r);
  assign fix_h   = (rd_hi < lob_r) ? lob_r - 1'b1 : rd_hi;

  // append operands, swapped when backwards except the pair 1-0
  always_comb begin
    app_lo = in_low_bound;
    app_hi = in_high_bound;
    if (!(in_low_bound == NW'(1) && in_high_bound == '0) && in_high_bound < in_low_bound) begin
      app_lo = in_high_bound;
      app_hi = in_low_bound;
    end
  end

  // control and datapath
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    d_nxt         = d_r;
    pos_nxt       = pos_r;
    kind_nxt      = kind_r;
    num_nxt       = num_r;
    lob_nxt       = lob_r;
    hib_nxt       = hib_r;
    sav_lo_nxt    = sav_lo_r;
    ins_lo_nxt    = ins_lo_r;
    ins_hi_nxt    = ins_hi_r;
    ov_nxt        = 1'b0;
    res_read_nxt  = res_read_r;
    res_first_nxt = res_first_r;
    res_elo_nxt   = res_elo_r;
    res_ehi_nxt   = res_ehi_r;
    res_ev_nxt    = res_ev_r;
    res_full_nxt  = res_full_r;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    raddr         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt      = in_kind;
          num_nxt       = in_number;
          lob_nxt       = in_low_bound;
          hib_nxt       = in_high_bound;
          res_read_nxt  = 1'b0;
          res_first_nxt = '0;
          res_elo_nxt   = '0;
          res_ehi_nxt   = '0;
          res_ev_nxt    = 1'b0;
          res_full_nxt  = 1'b0;
          unique case (in_kind) inside
            rrst_pkg::KIND_MARK, rrst_pkg::KIND_QUERY: begin
              i_nxt     = '0;
              state_nxt = S_WALK;
            end
            rrst_pkg::KIND_APPEND: begin
              ins_lo_nxt = app_lo;
              ins_hi_nxt = app_hi;
              if (cnt_r == '0) begin
                pos_nxt   = cnt_r;
                state_nxt = S_INSCHK;
              end else begin
                raddr     = AW'(cnt_r - 1'b1);
                state_nxt = S_ALAST;
              end
            end
            rrst_pkg::KIND_FIX: begin
              if (cnt_r == '0) begin
                state_nxt = S_FNONE;
              end else begin
                raddr     = AW'(cnt_r - 1'b1);
                state_nxt = S_FLAST;
              end
            end
            rrst_pkg::KIND_FIRST: begin
              if (cnt_r == '0) begin
                res_first_nxt = in_low_bound;
                ov_nxt        = 1'b1;
              end else begin
                state_nxt = S_FIRST;
              end
            end
            rrst_pkg::KIND_READ: begin
              if (32'(in_entry_index) < 32'(cnt_r)) begin
                raddr     = AW'(in_entry_index);
                state_nxt = S_RDENT;
              end else begin
                ov_nxt = 1'b1;
              end
            end
            default: ov_nxt = 1'b1;
          endcase
        end
      end

      // one entry per cycle; entry i is in rdata, entry i+1 is being read
      S_WALK: begin
        raddr = AW'(i_r + 1'b1);
        if (kind_r == rrst_pkg::KIND_MARK) begin
          if (w_end) begin
            pos_nxt    = cnt_r;
            ins_lo_nxt = num_r;
            ins_hi_nxt = num_r;
            state_nxt  = S_INSCHK;
          end else if (n1 < rd_lo32) begin
            pos_nxt    = i_r;
            ins_lo_nxt = num_r;
            ins_hi_nxt = num_r;
            state_nxt  = S_INSCHK;
          end else if (n1 == rd_lo32) begin
            we        = 1'b1;
            waddr     = AW'(i_r);
            wdata     = {num_r, rd_hi};
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end else if (num_r >= rd_lo && num_r <= rd_hi) begin
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end else if ({1'b0, num_r} == hi1) begin
            sav_lo_nxt = rd_lo;
            state_nxt  = S_MJOIN;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else if (kind_r == rrst_pkg::KIND_QUERY) begin
          if (w_end || num_r < rd_lo) begin
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end else if (num_r <= rd_hi) begin
            res_read_nxt = 1'b1;
            ov_nxt       = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          // fix: find the first entry that reaches the low bound
          if (w_end) begin
            state_nxt = S_FNONE;
          end else if (rd_lo > lob_r || rd_hi >= lob_r) begin
            we    = 1'b1;
            waddr = '0;
            wdata = {NW'(1), fix_h};
            if (32'(i_r) + 1 < 32'(cnt_r)) begin
              j_nxt     = i_r + 1'b1;
              d_nxt     = CW'(1);
              state_nxt = S_COPY;
            end else begin
              cnt_nxt   = cnt_r - i_r;
              ov_nxt    = 1'b1;
              state_nxt = S_IDLE;
            end
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end
      end

      // number sits just above entry i; rdata holds entry i+1
      S_MJOIN: begin
        we    = 1'b1;
        waddr = AW'(i_r);
        if (32'(i_r) + 1 < 32'(cnt_r) && n1 == rd_lo32) begin
          wdata = {sav_lo_r, rd_hi};
          if (32'(i_r) + 2 < 32'(cnt_r)) begin
            raddr     = AW'(i_r + 2'd2);
            j_nxt     = i_r + 2'd2;
            d_nxt     = i_r + 1'b1;
            state_nxt = S_COPY;
          end else begin
            cnt_nxt   = cnt_r - 1'b1;
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          wdata     = {sav_lo_r, num_r};
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      // move entries down: source j in rdata, destination d
      S_COPY: begin
        we    = 1'b1;
        waddr = AW'(d_r);
        wdata = rdata;
        if (j_r == cnt_r - 1'b1) begin
          cnt_nxt   = d_r + 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          raddr = AW'(j_r + 1'b1);
          j_nxt = j_r + 1'b1;
          d_nxt = d_r + 1'b1;
        end
      end

      // room check before opening a slot
      S_INSCHK: begin
        if (32'(cnt_r) >= MAX_RANGES) begin
          res_full_nxt = 1'b1;
          ov_nxt       = 1'b1;
          state_nxt    = S_IDLE;
        end else if (pos_r == cnt_r) begin
          state_nxt = S_INS;
        end else begin
          raddr     = AW'(cnt_r - 1'b1);
          j_nxt     = cnt_r - 1'b1;
          state_nxt = S_SHUP;
        end
      end

      // move entries up: source j in rdata, destination j+1
      S_SHUP: begin
        we    = 1'b1;
        waddr = AW'(j_r + 1'b1);
        wdata = rdata;
        if (j_r == pos_r) begin
          state_nxt = S_INS;
        end else begin
          raddr = AW'(j_r - 1'b1);
          j_nxt = j_r - 1'b1;
        end
      end

      S_INS: begin
        we        = 1'b1;
        waddr     = AW'(pos_r);
        wdata     = {ins_lo_r, ins_hi_r};
        cnt_nxt   = cnt_r + 1'b1;
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end

      // append: rdata holds the last entry
      S_ALAST: begin
        if ({1'b0, ins_lo_r} <= hi1) begin
          we        = 1'b1;
          waddr     = AW'(cnt_r - 1'b1);
          wdata     = {(ins_lo_r < rd_lo) ? ins_lo_r : rd_lo,
                       (ins_hi_r > rd_hi) ? ins_hi_r : rd_hi};
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          pos_nxt   = cnt_r;
          state_nxt = S_INSCHK;
        end
      end

      // fix: rdata holds the last entry
      S_FLAST: begin
        if (rd_hi > hib_r) begin
          we        = 1'b1;
          waddr     = '0;
          wdata     = {NW'(1), hib_r};
          cnt_nxt   = CW'(1);
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          i_nxt     = '0;
          state_nxt = S_WALK;
        end
      end

      // fix with nothing kept
      S_FNONE: begin
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
        if (lob_r <= NW'(1)) begin
          cnt_nxt = '0;
        end else begin
          we      = 1'b1;
          waddr   = '0;
          wdata   = {NW'(1), lob_r - 1'b1};
          cnt_nxt = CW'(1);
        end
      end

      S_FIRST: begin
        res_first_nxt = rd_hi + 1'b1;
        ov_nxt        = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_RDENT: begin
        res_elo_nxt = rd_lo;
        res_ehi_nxt = rd_hi;
        res_ev_nxt  = 1'b1;
        ov_nxt      = 1'b1;
        state_nxt   = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    d_r         <= d_nxt;
    pos_r       <= pos_nxt;
    kind_r      <= kind_nxt;
    num_r       <= num_nxt;
    lob_r       <= lob_nxt;
    hib_r       <= hib_nxt;
    sav_lo_r    <= sav_lo_nxt;
    ins_lo_r    <= ins_lo_nxt;
    ins_hi_r    <= ins_hi_nxt;
    res_read_r  <= res_read_nxt;
    res_first_r <= res_first_nxt;
    res_elo_r   <= res_elo_nxt;
    res_ehi_r   <= res_ehi_nxt;
    res_ev_r    <= res_ev_nxt;
    res_full_r  <= res_full_nxt;
  end

  // result ports
  assign busy             = (state_r != S_IDLE);
  assign out_valid        = ov_r;
  assign out_is_read      = res_read_r;
  assign out_first_unread = res_first_r;
  assign out_entry_low    = res_elo_r;
  assign out_entry_high   = res_ehi_r;
  assign out_entry_valid  = res_ev_r;
  assign out_table_full   = res_full_r;
  assign out_range_count  = rrst_pkg::CountW'(cnt_r);
endmodule
`default_nettype wire
